@@ src/eip_pkg.sv @@
// Shared types, constants and a helper function for the Ethernet/IPv4/L4 header parser.
`default_nettype none
package eip_pkg;

  localparam int LEN_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] POS_ETYPE_HI  = LEN_W'(12);
  localparam logic [LEN_W-1:0] POS_ETYPE_LO  = LEN_W'(13);
  localparam logic [LEN_W-1:0] POS_PROTO     = LEN_W'(23);
  localparam logic [LEN_W-1:0] POS_SRC_IP    = LEN_W'(26);
  localparam logic [LEN_W-1:0] POS_DST_IP    = LEN_W'(30);
  localparam logic [LEN_W-1:0] POS_SRC_PORT  = LEN_W'(34);
  localparam logic [LEN_W-1:0] POS_DST_PORT  = LEN_W'(36);
  localparam logic [LEN_W-1:0] POS_TCP_FLAGS = LEN_W'(47);

  localparam logic [LEN_W-1:0] ETH_HDR_END = LEN_W'(14);
  localparam logic [LEN_W-1:0] IP_HDR_END  = LEN_W'(34);
  localparam logic [LEN_W-1:0] TCP_HDR_END = LEN_W'(54);
  localparam logic [LEN_W-1:0] UDP_HDR_END = LEN_W'(42);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [17:0] FLAG_CODE_NONE = 18'd111111;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_NOT_IP = 2'd2,
    ST_NOT_L4 = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  l4_protocol;
    logic [17:0] flag_code;
    logic [15:0] packet_length;
    logic [15:0] payload_length;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]      ether_type;
    logic [7:0]       proto;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [5:0]       tcp_flags;
    logic [LEN_W-1:0] count;
  } hdr_t;

  typedef struct packed {
    logic fire;
    logic last;
  } step_t;

  // Each set flag turns its decimal digit from 1 into 2.
  function automatic logic [17:0] flag_code_f(input logic [5:0] bits);
    logic [17:0] code;
    code = FLAG_CODE_NONE;
    if (bits[5]) code = code + 18'd100000;
    if (bits[4]) code = code + 18'd10000;
    if (bits[3]) code = code + 18'd1000;
    if (bits[2]) code = code + 18'd100;
    if (bits[1]) code = code + 18'd10;
    if (bits[0]) code = code + 18'd1;
    return code;
  endfunction

endpackage
`default_nettype wire

@@ src/eip_capture.sv @@
// Byte counter and header field capture registers for one frame.
`default_nettype none
module eip_capture import eip_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire step_t step,
  input  wire logic [7:0] data_byte,
  output hdr_t       hdr_view
);

  hdr_t hdr_r;
  hdr_t hdr_nxt;
  logic [LEN_W-1:0] pos;

  assign pos = hdr_r.count;

  always_comb begin
    hdr_nxt = hdr_r;
    if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) begin
      hdr_nxt.ether_type = {hdr_r.ether_type[7:0], data_byte};
    end
    if (pos == POS_PROTO) begin
      hdr_nxt.proto = data_byte;
    end
    if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
      hdr_nxt.src_ip = {hdr_r.src_ip[23:0], data_byte};
    end
    if (pos >= POS_DST_IP && pos < POS_SRC_PORT) begin
      hdr_nxt.dst_ip = {hdr_r.dst_ip[23:0], data_byte};
    end
    if (pos == POS_SRC_PORT || pos == POS_SRC_PORT + LEN_W'(1)) begin
      hdr_nxt.sport = {hdr_r.sport[7:0], data_byte};
    end
    if (pos == POS_DST_PORT || pos == POS_DST_PORT + LEN_W'(1)) begin
      hdr_nxt.dport = {hdr_r.dport[7:0], data_byte};
    end
    if (pos == POS_TCP_FLAGS) begin
      hdr_nxt.tcp_flags = data_byte[5:0];
    end
    if (hdr_r.count != LEN_MAX) begin
      hdr_nxt.count = hdr_r.count + LEN_W'(1);
    end
  end

  assign hdr_view = hdr_nxt;

  // The final beat of a frame returns every capture to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        hdr_r <= '0;
      end else begin
        hdr_r <= hdr_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/eip_result.sv @@
// Frame status decision and result register.
`default_nettype none
module eip_result import eip_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire step_t step,
  input  wire hdr_t  hdr_view,
  input  wire logic  out_free,
  output logic       res_valid,
  output out_beat_t  res_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_beat_t data_r;
  out_beat_t data_nxt;
  status_t   status;
  logic [LEN_W-1:0] hdr_len;
  logic [LEN_W-1:0] len;

  assign len = hdr_view.count;

  always_comb begin
    hdr_len = TCP_HDR_END;
    priority if (len < ETH_HDR_END) begin
      status = ST_TRUNC;
    end else if (hdr_view.ether_type != ETHERTYPE_IPV4) begin
      status = ST_NOT_IP;
    end else if (len < IP_HDR_END) begin
      status = ST_TRUNC;
    end else if (hdr_view.proto == PROTO_TCP) begin
      status = (len < TCP_HDR_END) ? ST_TRUNC : ST_OK;
    end else if (hdr_view.proto == PROTO_UDP) begin
      hdr_len = UDP_HDR_END;
      status = (len < UDP_HDR_END) ? ST_TRUNC : ST_OK;
    end else begin
      status = ST_NOT_L4;
    end
  end

  always_comb begin
    data_nxt = '0;
    data_nxt.status = status;
    data_nxt.packet_length = 16'(len);
    if (status == ST_OK) begin
      data_nxt.src_ip = hdr_view.src_ip;
      data_nxt.dst_ip = hdr_view.dst_ip;
      data_nxt.sport = hdr_view.sport;
      data_nxt.dport = hdr_view.dport;
      data_nxt.l4_protocol = hdr_view.proto;
      data_nxt.flag_code = (hdr_view.proto == PROTO_TCP) ?
                           flag_code_f(hdr_view.tcp_flags) : FLAG_CODE_NONE;
      data_nxt.payload_length = 16'(len - hdr_len);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = step.fire && step.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.last) begin
      data_r <= data_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_data  = data_r;

endmodule
`default_nettype wire

@@ src/eth_ipv4_l4_header_parser.sv @@
// Top level of the Ethernet/IPv4/L4 header parser: input register, capture and result.
//
//   Channel | Direction | Payload    | Handshake
//   in_     | input     | in_beat_t  | in_valid / in_stall
//   out_    | output    | out_beat_t | out_valid / out_stall
//
// Each byte is held in the input register and is then folded into the capture
// registers; a frame's result is loaded into the result register at the edge where
// its last byte leaves the input register.
// One byte is taken every cycle while results drain; the input stalls only when the
// input register holds a byte and the result register holds a beat that is stalled.
// Synchronous active-low reset empties both registers and clears all captures.
`default_nettype none
module eth_ipv4_l4_header_parser import eip_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_beat_t s1_data_r;
  logic     out_free;
  logic     in_accept;
  step_t    step;
  hdr_t     hdr_view;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign step.fire = s1_valid_r && out_free;
  assign step.last = s1_data_r.last_byte;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (step.fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  eip_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (s1_data_r.packet_byte),
    .hdr_view  (hdr_view)
  );

  eip_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .hdr_view  (hdr_view),
    .out_free  (out_free),
    .res_valid (out_valid),
    .res_data  (out_data)
  );

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.src_ip == 32'd0 && out_data.payload_length == 16'd0)
    else $error("Failed frame carries non-zero header fields");

  a_ok_min_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.packet_length >= 16'd42)
    else $error("Good frame shorter than the smallest header");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.last |=> out_valid)
    else $error("Last byte processed without a result beat");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid)
    else $error("Input stalled with nothing held");

endmodule
`default_nettype wire

@@ verif/tb_eth_ipv4_l4_header_parser.sv @@
// Self-checking testbench for the Ethernet/IPv4/L4 header parser.
`default_nettype none
module tb_eth_ipv4_l4_header_parser;
  import eip_pkg::*;

  localparam logic [1:0] FILL_RAND = 2'd0;
  localparam logic [1:0] FILL_ZERO = 2'd1;
  localparam logic [1:0] FILL_ONES = 2'd2;

  localparam int unsigned RAND_BYTES    = 800;
  localparam int unsigned RAND_FRAMES   = 12;
  localparam int unsigned QUIET_BYTES   = 600;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [31:0] len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [5:0]  flags;
    logic [1:0]  fill;
    logic        typed;
    status_t     st;
  } frame_row_t;

  localparam int DIR_ROWS = 21;
  localparam frame_row_t DIR_TAB [DIR_ROWS] = '{
    '{32'd1,     16'h0800, PROTO_TCP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd13,    16'h0800, PROTO_TCP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd14,    16'h86DD, PROTO_TCP, 6'h00, FILL_ONES, 1'b1, ST_NOT_IP},
    '{32'd14,    16'h0800, PROTO_TCP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd33,    16'h0800, PROTO_TCP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd34,    16'h0800, PROTO_TCP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd34,    16'h0800, 8'd1,      6'h00, FILL_RAND, 1'b1, ST_NOT_L4},
    '{32'd53,    16'h0800, PROTO_TCP, 6'h3F, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd54,    16'h0800, PROTO_TCP, 6'h00, FILL_ZERO, 1'b0, ST_OK},
    '{32'd54,    16'h0800, PROTO_TCP, 6'h3F, FILL_ONES, 1'b0, ST_OK},
    '{32'd41,    16'h0800, PROTO_UDP, 6'h00, FILL_RAND, 1'b1, ST_TRUNC},
    '{32'd42,    16'h0800, PROTO_UDP, 6'h3F, FILL_ONES, 1'b0, ST_OK},
    '{32'd42,    16'h0800, PROTO_UDP, 6'h00, FILL_ZERO, 1'b0, ST_OK},
    '{32'd60,    16'h0000, PROTO_TCP, 6'h00, FILL_ZERO, 1'b1, ST_NOT_IP},
    '{32'd60,    16'hFFFF, PROTO_TCP, 6'h3F, FILL_ONES, 1'b1, ST_NOT_IP},
    '{32'd60,    16'h0801, PROTO_UDP, 6'h00, FILL_RAND, 1'b1, ST_NOT_IP},
    '{32'd60,    16'h0800, 8'hFF,     6'h3F, FILL_ONES, 1'b1, ST_NOT_L4},
    '{32'd60,    16'h0800, 8'h00,     6'h00, FILL_ZERO, 1'b1, ST_NOT_L4},
    '{32'd120,   16'h0800, PROTO_TCP, 6'h2A, FILL_RAND, 1'b0, ST_OK},
    '{32'd90,    16'h0800, PROTO_TCP, 6'h15, FILL_RAND, 1'b0, ST_OK},
    '{32'd70,    16'h0800, PROTO_TCP, 6'h01, FILL_RAND, 1'b0, ST_OK}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  eth_ipv4_l4_header_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  logic [15:0] sh_count = '0;
  logic [15:0] sh_etype = '0;
  logic [7:0]  sh_proto = '0;
  logic [31:0] sh_sip = '0;
  logic [31:0] sh_dip = '0;
  logic [15:0] sh_sport = '0;
  logic [15:0] sh_dport = '0;
  logic [5:0]  sh_flags = '0;

  out_beat_t   pending_tuples[$];
  int unsigned mismatch_cnt = 0;
  int unsigned tuples_checked = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned stalled_beats = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_len = 0;

  // Folds one byte into the shadow header state; returns 1 with the tuple on a last byte.
  function automatic bit parse_byte(input in_beat_t beat, output out_beat_t tuple);
    logic [15:0] pos;
    logic [15:0] hdr_len;
    logic [7:0]  b;
    logic [17:0] code;
    status_t     st;
    pos = sh_count;
    b = beat.packet_byte;
    tuple = '0;
    hdr_len = '0;
    if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) sh_etype = {sh_etype[7:0], b};
    else if (pos == POS_PROTO) sh_proto = b;
    else if (pos >= POS_SRC_IP && pos < POS_DST_IP) sh_sip = {sh_sip[23:0], b};
    else if (pos >= POS_DST_IP && pos < POS_SRC_PORT) sh_dip = {sh_dip[23:0], b};
    else if (pos >= POS_SRC_PORT && pos < POS_DST_PORT) sh_sport = {sh_sport[7:0], b};
    else if (pos == POS_DST_PORT || pos == POS_DST_PORT + 16'd1) sh_dport = {sh_dport[7:0], b};
    else if (pos == POS_TCP_FLAGS) sh_flags = b[5:0];
    if (sh_count != LEN_MAX) sh_count = sh_count + 16'd1;
    if (!beat.last_byte) return 1'b0;

    if (sh_count < ETH_HDR_END) st = ST_TRUNC;
    else if (sh_etype != ETHERTYPE_IPV4) st = ST_NOT_IP;
    else if (sh_count < IP_HDR_END) st = ST_TRUNC;
    else if (sh_proto == PROTO_TCP) begin
      hdr_len = TCP_HDR_END;
      st = (sh_count < hdr_len) ? ST_TRUNC : ST_OK;
    end else if (sh_proto == PROTO_UDP) begin
      hdr_len = UDP_HDR_END;
      st = (sh_count < hdr_len) ? ST_TRUNC : ST_OK;
    end else st = ST_NOT_L4;

    tuple.status = st;
    tuple.packet_length = sh_count;
    if (st == ST_OK) begin
      code = FLAG_CODE_NONE;
      if (sh_proto == PROTO_TCP) begin
        code = '0;
        for (int i = 5; i >= 0; i--) code = code * 18'd10 + (sh_flags[i] ? 18'd2 : 18'd1);
      end
      tuple.src_ip = sh_sip;
      tuple.dst_ip = sh_dip;
      tuple.sport = sh_sport;
      tuple.dport = sh_dport;
      tuple.l4_protocol = sh_proto;
      tuple.flag_code = code;
      tuple.payload_length = sh_count - hdr_len;
    end

    sh_count = '0;
    sh_etype = '0;
    sh_proto = '0;
    sh_sip = '0;
    sh_dip = '0;
    sh_sport = '0;
    sh_dport = '0;
    sh_flags = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h, want %0h", tuples_checked, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_beat(input in_beat_t beat);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) begin
      stalled_beats++;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned flen, input logic [15:0] etype,
                            input logic [7:0] proto, input logic [5:0] flags,
                            input logic [1:0] fill, input bit typed, input status_t st);
    in_beat_t  beat;
    out_beat_t tuple;
    logic [7:0] filler;
    for (int unsigned pos = 0; pos < flen; pos++) begin
      case (fill)
        FILL_ZERO: filler = 8'h00;
        FILL_ONES: filler = 8'hFF;
        default:   filler = 8'($urandom);
      endcase
      if (pos == 12) beat.packet_byte = etype[15:8];
      else if (pos == 13) beat.packet_byte = etype[7:0];
      else if (pos == 23) beat.packet_byte = proto;
      else if (pos == 47) beat.packet_byte = {filler[7:6], flags};
      else beat.packet_byte = filler;
      beat.last_byte = (pos == flen - 1);
      send_beat(beat);
      if (parse_byte(beat, tuple)) begin
        if (typed) begin
          tuple = '0;
          tuple.status = st;
          tuple.packet_length = flen[15:0];
        end
        pending_tuples.push_back(tuple);
      end
    end
    frames_sent++;
  endtask

  always @(posedge clk) begin : tuple_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tuples.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data.status), 32'd0);
      end else begin
        want = pending_tuples.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.src_ip != want.src_ip)
          report_mismatch("src_ip", out_data.src_ip, want.src_ip);
        if (out_data.dst_ip != want.dst_ip)
          report_mismatch("dst_ip", out_data.dst_ip, want.dst_ip);
        if (out_data.sport != want.sport)
          report_mismatch("sport", 32'(out_data.sport), 32'(want.sport));
        if (out_data.dport != want.dport)
          report_mismatch("dport", 32'(out_data.dport), 32'(want.dport));
        if (out_data.l4_protocol != want.l4_protocol)
          report_mismatch("l4_protocol", 32'(out_data.l4_protocol), 32'(want.l4_protocol));
        if (out_data.flag_code != want.flag_code)
          report_mismatch("flag_code", 32'(out_data.flag_code), 32'(want.flag_code));
        if (out_data.packet_length != want.packet_length)
          report_mismatch("packet_length", 32'(out_data.packet_length),
                          32'(want.packet_length));
        if (out_data.payload_length != want.payload_length)
          report_mismatch("payload_length", 32'(out_data.payload_length),
                          32'(want.payload_length));
      end
      tuples_checked++;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #40000000;
    $display("tb_eth_ipv4_l4_header_parser: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_frames;
    int unsigned rand_bytes;
    int unsigned start_bytes;
    int unsigned flen;
    logic [15:0] etype;
    logic [7:0]  proto;
    bit          pressure_done;
    rand_frames = 0;
    rand_bytes = 0;
    pressure_done = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i])
      send_frame(DIR_TAB[i].len, DIR_TAB[i].etype, DIR_TAB[i].proto, DIR_TAB[i].flags,
                 DIR_TAB[i].fill, DIR_TAB[i].typed, DIR_TAB[i].st);

    start_bytes = bytes_sent;
    while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
      idle_on = (rand_bytes < QUIET_BYTES);
      if (rand_frames == 4 && !pressure_done) begin
        hold_len = HOLD_CYCLES;
        hold_req = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        etype = ETHERTYPE_IPV4;
        proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        flen = (proto == PROTO_TCP) ? 54 : 42;
        flen += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      end else begin
        flen = $urandom_range(1, 60);
        etype = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
        case ($urandom_range(0, 2))
          0:       proto = PROTO_TCP;
          1:       proto = PROTO_UDP;
          default: proto = 8'($urandom);
        endcase
      end
      send_frame(flen, etype, proto, 6'($urandom), FILL_RAND, 1'b0, ST_OK);
      rand_frames++;
      rand_bytes = bytes_sent - start_bytes;
    end

    in_valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_tuples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames in %0d byte beats (%0d random frames), checked %0d results.",
             frames_sent, bytes_sent, rand_frames, tuples_checked);
    $display("Covered every status, runt and minimum-size frames and %0d stalled input beats.",
             stalled_beats);
    if (mismatch_cnt == 0) begin
      $display("tb_eth_ipv4_l4_header_parser: done, clean");
    end else begin
      $display("tb_eth_ipv4_l4_header_parser: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/eip_pkg.sv
src/eip_capture.sv
src/eip_result.sv
src/eth_ipv4_l4_header_parser.sv
verif/tb_eth_ipv4_l4_header_parser.sv
